>>> hw/rtl/kmp_pkg.sv
// ----------------------------------------------------------------------------
// KMP string matcher package
// Shared sizes, transaction payload types and controller states.
// ----------------------------------------------------------------------------
package kmp_pkg;

    // Longest pattern the block can hold.
    localparam int PATTERN_MAX = 64;

    // Index into the pattern and failure stores.
    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    // A length runs from zero up to and including PATTERN_MAX.
    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    localparam logic [LEN_W-1:0] PAT_MAX_LEN = LEN_W'(PATTERN_MAX);
    localparam logic [LEN_W-1:0] LEN_ZERO    = '0;
    localparam logic [LEN_W-1:0] LEN_ONE     = LEN_W'(1);

    // Item kinds.
    localparam logic KIND_PATTERN = 1'b0;
    localparam logic KIND_TEXT    = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic       pattern_end;
        logic       text_start;
    } t_item;

    typedef struct packed {
        logic [31:0] match_start;
        logic        position_saturated;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_FALL,
        ST_MATCH
    } t_state;

endpackage

>>> hw/rtl/kmp_ram.sv
// ----------------------------------------------------------------------------
// KMP generic RAM
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module kmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                           i_clk,
    input  logic                                           i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   i_wr_addr,
    input  logic [WIDTH-1:0]                               i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   i_rd_addr,
    output logic [WIDTH-1:0]                               o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

>>> hw/rtl/kmp_string_matcher.sv
// ----------------------------------------------------------------------------
// KMP string matcher
// Streaming Knuth-Morris-Pratt search with an incrementally built failure table.
// ----------------------------------------------------------------------------
// Sequencing: the first pattern byte, a dropped pattern byte and a text byte while
//   unarmed finish in the cycle of acceptance; any other byte goes through compare,
//   then fallback and compare again per fallback, and a match adds the match state, held while the result stalls.
// Throughput: one transaction at a time; each fallback costs one pattern-store
//   read and one failure-table read, both through synchronous registered-read RAMs.
// Reset clears the controller, lengths, position and result valid; not the stores.
// ----------------------------------------------------------------------------
module kmp_string_matcher
    import kmp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_item   i_item,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state            r_state, n_state;
    logic [LEN_W-1:0]  r_len, n_len;          // stored pattern length
    logic [LEN_W-1:0]  r_prefix, n_prefix;    // failure value of last pattern byte
    logic [LEN_W-1:0]  r_match, n_match;      // current match length over the text
    logic [31:0]       r_pos, n_pos;          // index of the next text byte
    logic              r_sat, n_sat;          // position counter has saturated
    logic              r_armed, n_armed;
    logic [LEN_W-1:0]  r_k, n_k;              // working prefix length of the search
    logic [7:0]        r_b, n_b;              // byte being worked on
    logic              r_kind, n_kind;
    logic              r_last, n_last;
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    logic              store_we;
    logic [IDX_W-1:0]  store_waddr;
    logic [7:0]        store_wdata;
    logic [IDX_W-1:0]  store_raddr;
    logic [7:0]        store_q;

    logic              fail_we;
    logic [IDX_W-1:0]  fail_waddr;
    logic [LEN_W-1:0]  fail_wdata;
    logic [IDX_W-1:0]  fail_raddr;
    logic [LEN_W-1:0]  fail_q;

    kmp_ram #(.WIDTH(8), .DEPTH(PATTERN_MAX)) u_pattern_store (
        .i_clk     (i_clk),
        .i_wr_en   (store_we),
        .i_wr_addr (store_waddr),
        .i_wr_data (store_wdata),
        .i_rd_addr (store_raddr),
        .o_rd_data (store_q)
    );

    kmp_ram #(.WIDTH(LEN_W), .DEPTH(PATTERN_MAX)) u_failure_table (
        .i_clk     (i_clk),
        .i_wr_en   (fail_we),
        .i_wr_addr (fail_waddr),
        .i_wr_data (fail_wdata),
        .i_rd_addr (fail_raddr),
        .o_rd_data (fail_q)
    );

    // ------------------------------------------------------------------
    // Shared decode
    // ------------------------------------------------------------------
    logic              accept;
    logic              out_free;
    logic              byte_eq;
    logic              fall_back;
    logic [LEN_W-1:0]  k_next;
    logic [LEN_W-1:0]  pat_len_eff;
    logic [LEN_W-1:0]  pat_prefix_eff;
    logic [LEN_W-1:0]  txt_match_eff;
    logic [LEN_W-1:0]  txt_k0;

    assign accept   = i_valid && (r_state == ST_IDLE);
    // The result register can be loaded when it is empty or being drained.
    assign out_free = !r_out_valid || !i_stall;

    // In the compare state the pattern store answers for entry r_k.
    assign byte_eq   = (r_b == store_q);
    assign fall_back = (r_k != LEN_ZERO) && !byte_eq;
    assign k_next    = r_k + LEN_W'(byte_eq);

    // A pattern byte arriving while armed starts a fresh pattern.
    assign pat_len_eff    = r_armed ? LEN_ZERO : r_len;
    assign pat_prefix_eff = r_armed ? LEN_ZERO : r_prefix;

    // A text-start byte restarts the match; a stale length is treated as zero.
    assign txt_match_eff = i_item.text_start ? LEN_ZERO : r_match;
    assign txt_k0        = (txt_match_eff >= r_len) ? LEN_ZERO : txt_match_eff;

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_item.kind == KIND_PATTERN) begin
                        if (pat_len_eff < PAT_MAX_LEN && pat_len_eff != LEN_ZERO) begin
                            n_state = ST_CMP;
                        end
                    end else if (r_armed) begin
                        n_state = ST_CMP;
                    end
                end
            end
            ST_CMP: begin
                if (fall_back) begin
                    n_state = ST_FALL;
                end else if (r_kind == KIND_TEXT && k_next == r_len) begin
                    n_state = ST_MATCH;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_FALL: begin
                n_state = ST_CMP;
            end
            ST_MATCH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and memory control
    // ------------------------------------------------------------------
    always_comb begin
        n_len       = r_len;
        n_prefix    = r_prefix;
        n_match     = r_match;
        n_pos       = r_pos;
        n_sat       = r_sat;
        n_armed     = r_armed;
        n_k         = r_k;
        n_b         = r_b;
        n_kind      = r_kind;
        n_last      = r_last;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;

        store_we    = 1'b0;
        store_waddr = r_len[IDX_W-1:0];
        store_wdata = r_b;
        store_raddr = r_k[IDX_W-1:0];
        fail_we     = 1'b0;
        fail_waddr  = r_len[IDX_W-1:0];
        fail_wdata  = k_next;
        fail_raddr  = r_k[IDX_W-1:0] - IDX_W'(1);

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_b    = i_item.data_byte;
                    n_kind = i_item.kind;
                    n_last = i_item.pattern_end;
                    if (i_item.kind == KIND_PATTERN) begin
                        n_armed  = 1'b0;
                        n_len    = pat_len_eff;
                        n_prefix = pat_prefix_eff;
                        if (pat_len_eff == LEN_ZERO) begin
                            // First byte: its failure value is zero by definition.
                            store_we    = 1'b1;
                            store_waddr = '0;
                            store_wdata = i_item.data_byte;
                            fail_we     = 1'b1;
                            fail_waddr  = '0;
                            fail_wdata  = LEN_ZERO;
                            n_len       = LEN_ONE;
                            n_prefix    = LEN_ZERO;
                            if (i_item.pattern_end) begin
                                n_armed = 1'b1;
                                n_match = LEN_ZERO;
                                n_pos   = '0;
                                n_sat   = 1'b0;
                            end
                        end else if (pat_len_eff < PAT_MAX_LEN) begin
                            n_k         = pat_prefix_eff;
                            store_raddr = pat_prefix_eff[IDX_W-1:0];
                        end else if (i_item.pattern_end) begin
                            // Pattern full: the byte is dropped but still arms.
                            n_armed = 1'b1;
                            n_match = LEN_ZERO;
                            n_pos   = '0;
                            n_sat   = 1'b0;
                        end
                    end else begin
                        if (i_item.text_start) begin
                            n_pos   = '0;
                            n_match = LEN_ZERO;
                            n_sat   = 1'b0;
                        end
                        n_k         = txt_k0;
                        store_raddr = txt_k0[IDX_W-1:0];
                    end
                end
            end
            ST_CMP: begin
                if (fall_back) begin
                    fail_raddr = r_k[IDX_W-1:0] - IDX_W'(1);
                end else if (r_kind == KIND_PATTERN) begin
                    store_we = 1'b1;
                    fail_we  = 1'b1;
                    n_prefix = k_next;
                    n_len    = r_len + LEN_ONE;
                    if (r_last) begin
                        n_armed = 1'b1;
                        n_match = LEN_ZERO;
                        n_pos   = '0;
                        n_sat   = 1'b0;
                    end
                end else if (k_next == r_len) begin
                    n_k        = k_next;
                    fail_raddr = r_len[IDX_W-1:0] - IDX_W'(1);
                end else begin
                    n_match = k_next;
                    if (r_pos == '1) begin
                        n_sat = 1'b1;
                    end else begin
                        n_pos = r_pos + 32'd1;
                    end
                end
            end
            ST_FALL: begin
                n_k         = fail_q;
                store_raddr = fail_q[IDX_W-1:0];
            end
            ST_MATCH: begin
                // Hold the read address so the failure value stays put while stalled.
                fail_raddr = r_len[IDX_W-1:0] - IDX_W'(1);
                if (out_free) begin
                    n_out_valid                = 1'b1;
                    n_out.match_start          = r_pos - 32'(r_len) + 32'd1;
                    n_out.position_saturated   = r_sat;
                    n_match                    = fail_q;
                    if (r_pos == '1) begin
                        n_sat = 1'b1;
                    end else begin
                        n_pos = r_pos + 32'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= LEN_ZERO;
            r_prefix    <= LEN_ZERO;
            r_match     <= LEN_ZERO;
            r_pos       <= '0;
            r_sat       <= 1'b0;
            r_armed     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_prefix    <= n_prefix;
            r_match     <= n_match;
            r_pos       <= n_pos;
            r_sat       <= n_sat;
            r_armed     <= n_armed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_b    <= n_b;
        r_kind <= n_kind;
        r_last <= n_last;
        r_out  <= n_out;
    end

    assign o_stall  = (r_state != ST_IDLE);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The matcher is only ever armed with a non-empty pattern.
    a_armed_has_pattern: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_armed |-> (r_len != LEN_ZERO))
        else $error("matcher armed with an empty pattern");

    // The stored length never exceeds the store depth.
    a_len_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= PAT_MAX_LEN)
        else $error("pattern length beyond store depth");

    // A failure value is always a proper prefix of the stored pattern.
    a_prefix_proper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len != LEN_ZERO) |-> (r_prefix < r_len))
        else $error("failure value not a proper prefix");

    // A fallback always returns to a compare in the next cycle.
    a_fall_to_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FALL) |=> (r_state == ST_CMP))
        else $error("fallback did not return to compare");

    // The match state is only entered with a full-length match.
    a_match_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MATCH) |-> (r_k == r_len && r_kind == KIND_TEXT))
        else $error("match state without a complete match");

endmodule
